>>> rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Phase encoding, field widths, word layout and the tick-to-cm conversion.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int CNT_W      = 12;
  localparam int LIM_W      = 8;
  localparam int DIST_W     = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [LIM_W-1:0] RISE_WAIT_RST = LIM_W'(50);
  localparam logic [CNT_W-1:0] MAX_ECHO_RST  = CNT_W'(2000);

  localparam logic [CFG_IDX_W-1:0] REG_RISE_WAIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO  = CFG_IDX_W'(1);

  // floor(t*17/100) == (t * ceil(17*2^20/100)) >> 20 for 12-bit t
  localparam int CM_SHIFT = 20;
  localparam int CM_MUL_W = 18;
  localparam logic [CM_MUL_W-1:0] CM_MUL = CM_MUL_W'(178258);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_MEAS = 2'd2
  } phase_t;

  typedef struct packed {
    logic              echo_timeout;
    logic [DIST_W-1:0] distance_cm;
    logic              done_res;
    logic              busy_res;
    logic              trigger;
  } result_t;

  function automatic logic [DIST_W-1:0] ticks_to_cm(input logic [CNT_W-1:0] ticks);
    logic [CNT_W+CM_MUL_W-1:0] prod;
    prod = {{CM_MUL_W{1'b0}}, ticks} * {{CNT_W{1'b0}}, CM_MUL};
    return prod[CM_SHIFT +: DIST_W];
  endfunction

endpackage

>>> rtl/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core: ranging sequencer
// Trigger, echo rise wait, echo width count and distance for one tick word.
// ----------------------------------------------------------------------------
module uer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic                          start_req,
  input  logic                          echo_level,
  input  logic [uer_pkg::LIM_W-1:0]     rise_wait_limit,
  input  logic [uer_pkg::CNT_W-1:0]     max_echo_ticks,
  output uer_pkg::result_t              res
);
  import uer_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc, dist_src;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              finish, tmo, trig;

  assign cnt_inc = cnt_r + CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    dist_nxt  = dist_r;
    dist_src  = cnt_r;
    finish    = 1'b0;
    tmo       = 1'b0;
    trig      = 1'b0;
    case (phase_r)
      PH_WAIT: begin
        if (echo_level) begin
          phase_nxt = PH_MEAS;
          cnt_nxt   = '0;
        end else if (cnt_inc >= {{(CNT_W-LIM_W){1'b0}}, rise_wait_limit}) begin
          phase_nxt = PH_MEAS;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_MEAS: begin
        if (cnt_r >= max_echo_ticks) begin
          finish = 1'b1;
          tmo    = 1'b1;
        end else if (!echo_level) begin
          finish = 1'b1;
        end else begin
          cnt_nxt  = cnt_inc;
          dist_src = cnt_inc;
          if (cnt_inc >= max_echo_ticks) begin
            finish = 1'b1;
            tmo    = 1'b1;
          end
        end
        if (finish) begin
          dist_nxt  = ticks_to_cm(dist_src);
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (start_req) begin
          trig      = 1'b1;
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      dist_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      dist_r  <= dist_nxt;
    end
  end

  assign res.trigger      = trig;
  assign res.busy_res     = (phase_nxt == PH_WAIT) || (phase_nxt == PH_MEAS);
  assign res.done_res     = finish;
  assign res.distance_cm  = dist_nxt;
  assign res.echo_timeout = tmo;

endmodule

>>> rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: HC-SR04 style echo ranging, one word per tick
// Stream in/out wrapper with config registers and a registered result word.
// ----------------------------------------------------------------------------
// Each accepted input word's result word is registered and is valid in the cycle after it is accepted.
// Throughput: 1 word per cycle while out_tready is high; the result register accepts a new word while
// its current word is taken in the same cycle.
// Reset (rst_n low, synchronous): phase idle, counters and distance zero,
// limits back to 50 and 2000, no result word pending.
module ultrasonic_echo_ranger (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [uer_pkg::IN_DATA_W-1:0]     in_tdata,   // [0] start_req, [1] echo_level
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [uer_pkg::OUT_DATA_W-1:0]    out_tdata,  // [0] trigger, [1] busy_res,
                                                        // [2] done_res, [12:3] distance_cm,
                                                        // [13] echo_timeout
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import uer_pkg::*;

  logic [LIM_W-1:0]      rise_lim_r;
  logic [CNT_W-1:0]      max_echo_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  take;
  result_t               res;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_lim_r <= RISE_WAIT_RST;
      max_echo_r <= MAX_ECHO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RISE_WAIT: rise_lim_r <= cfg_data[LIM_W-1:0];
        REG_MAX_ECHO:  max_echo_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  uer_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .start_req       (in_tdata[0]),
    .echo_level      (in_tdata[1]),
    .rise_wait_limit (rise_lim_r),
    .max_echo_ticks  (max_echo_r),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {{(OUT_DATA_W-$bits(result_t)){1'b0}}, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker: port-level checks of the ultrasonic echo ranger
// Result word consistency and handshake behavior, bound to the top level.
// ----------------------------------------------------------------------------
module uer_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [uer_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1] && !out_tdata[2])
    else $error("trigger without busy or with done");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1])
    else $error("done while still busy");

  a_tmo_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[2] && out_tdata[12:3] <= 10'd696)
    else $error("timeout flag without done or distance out of range");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
